// File: hw/rtl/vcdu_mpdu_packet_extractor_macros.svh
// assertion macros shared by the checker of the packet extractor
// expects i_clk and i_rst_n in the scope of each use
`ifndef VCDU_MPDU_PACKET_EXTRACTOR_MACROS_SVH
`define VCDU_MPDU_PACKET_EXTRACTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define VMPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define VMPE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/vmpe_pkg.sv
// shared types and constants of the vcdu m_pdu packet extractor
// no dependencies
package vmpe_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 2048;

    localparam int FL_W       = 12;
    localparam int DS_W       = 11;
    localparam int PTR_W      = 11;
    localparam int CH_W       = 6;
    localparam int CNT_W      = 24;
    localparam int SEG_W      = 12;
    localparam int LEN_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [PTR_W-1:0] IDLE_POINTER = 11'h7ff;

    // header byte positions
    localparam int POS_CHANNEL = 1;
    localparam int POS_CNT_HI  = 2;
    localparam int POS_CNT_MID = 3;
    localparam int POS_CNT_LO  = 4;
    localparam int PTR_AT_IZ   = 8;
    localparam int PTR_AT_NO   = 6;

    // offsets within a packet
    localparam int LEN_HI_OFS  = 4;
    localparam int LEN_LO_OFS  = 5;
    localparam int PKT_HDR_LEN = 6;

    // reset values of the configuration
    localparam logic [FL_W-1:0] RST_FRAME_LENGTH = 12'd1020;
    localparam logic [DS_W-1:0] RST_DATA_START   = 11'd10;
    localparam logic [DS_W-1:0] RST_DATA_SIZE    = 11'd1010;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LENGTH = 3'd0,
        REG_INSERT_ZONE  = 3'd1,
        REG_CHANNEL_ID   = 3'd2,
        REG_DATA_START   = 3'd3,
        REG_DATA_SIZE    = 3'd4,
        REG_IDLE_NEW     = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [FL_W-1:0] frame_length;
        logic            insert_zone_present;
        logic [CH_W-1:0] channel_id;
        logic [DS_W-1:0] data_start;
        logic [DS_W-1:0] data_size;
        logic            idle_pointer_always_new;
    } t_cfg;

    typedef struct packed {
        logic             starts_new_packet;
        logic             segment_last;
        logic             segment_first;
        logic [CNT_W-1:0] frame_count;
        logic [7:0]       packet_byte;
    } t_result;

endpackage

// File: hw/rtl/vmpe_core.sv
// frame header decode, data zone segmentation and per-byte result
// depends on vmpe_pkg
module vmpe_core #(
    parameter int MAX_FRAME_BYTES = vmpe_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vmpe_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output vmpe_pkg::t_result o_res
);
    import vmpe_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);
    localparam int CW    = ((POS_W > SEG_W) ? POS_W : SEG_W) + 1;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_cur, n_cur;
    logic [CNT_W-1:0] r_prev, n_prev;
    logic             r_match, n_match;
    logic             r_cont, n_cont;
    logic [PTR_W-1:0] r_hp, n_hp;
    logic [SEG_W-1:0] r_nps, n_nps;
    logic [SEG_W-1:0] r_seg_end, n_seg_end;
    logic [7:0]       r_lhb, n_lhb;

    logic [CW-1:0]    fl_c, ds_c, size_c, ptr_at_c, zone_c, pos_c, zoff_c, pos1_c;
    logic             zone_ok, in_zone, emit, first, last, fresh;
    logic [SEG_W-1:0] z, zone12;
    logic [LEN_W-1:0] len, cand;

    always_comb begin
        fl_c = CW'(i_cfg.frame_length);
        if (fl_c > CW'(MAX_FRAME_BYTES)) begin
            fl_c = CW'(MAX_FRAME_BYTES);
        end
        if (fl_c == '0) begin
            fl_c = CW'(1);
        end
        ds_c     = CW'(i_cfg.data_start);
        size_c   = CW'(i_cfg.data_size);
        ptr_at_c = i_cfg.insert_zone_present ? CW'(PTR_AT_IZ) : CW'(PTR_AT_NO);
        pos_c    = CW'(r_pos);
        pos1_c   = pos_c + CW'(1);

        zone_ok = (ds_c > ptr_at_c + CW'(1)) && (ds_c < fl_c);
        zone_c  = '0;
        if (zone_ok) begin
            zone_c = (ds_c + size_c > fl_c) ? (fl_c - ds_c) : size_c;
        end
        zoff_c = pos_c - ds_c;
        z      = zoff_c[SEG_W-1:0];
        zone12 = zone_c[SEG_W-1:0];

        n_pos     = r_pos;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_match   = r_match;
        n_cont    = r_cont;
        n_hp      = r_hp;
        n_nps     = r_nps;
        n_seg_end = r_seg_end;
        n_lhb     = r_lhb;
        in_zone   = 1'b0;
        emit      = 1'b0;
        first     = 1'b0;
        last      = 1'b0;
        fresh     = 1'b0;
        len       = '0;
        cand      = '0;

        if (i_valid) begin
            // header decode
            if (pos_c == '0) begin
                n_match = 1'b0;
            end
            if (pos_c == CW'(POS_CHANNEL)) begin
                n_match = (i_byte[CH_W-1:0] == i_cfg.channel_id);
            end
            if (pos_c == CW'(POS_CNT_HI)) begin
                n_cur = {i_byte, 16'h0000};
            end
            if (pos_c == CW'(POS_CNT_MID)) begin
                n_cur = {r_cur[23:16], r_cur[15:8] | i_byte, r_cur[7:0]};
            end
            if (pos_c == CW'(POS_CNT_LO)) begin
                n_cur = {r_cur[23:8], r_cur[7:0] | i_byte};
                if (r_match) begin
                    n_cont = (({1'b0, r_prev} + 25'd1) == {1'b0, n_cur});
                    n_prev = n_cur;
                end
            end
            if (pos_c == ptr_at_c) begin
                n_hp = {i_byte[2:0], 8'h00};
            end
            if (pos_c == ptr_at_c + CW'(1)) begin
                n_hp      = {r_hp[10:8], r_hp[7:0] | i_byte};
                n_nps     = SEG_W'(n_hp);
                n_seg_end = '0;
            end

            // data zone
            in_zone = zone_ok && n_match && (pos_c >= ds_c) && (zoff_c < zone_c);
            if (in_zone) begin
                if (r_hp == IDLE_POINTER) begin
                    fresh = i_cfg.idle_pointer_always_new;
                    emit  = fresh || r_cont;
                    first = (z == '0);
                    last  = (z + SEG_W'(1) == zone12);
                end else if (z < SEG_W'(r_hp)) begin
                    fresh = 1'b0;
                    emit  = r_cont;
                    first = (z == '0);
                    last  = (z + SEG_W'(1) == SEG_W'(r_hp)) || (z + SEG_W'(1) == zone12);
                end else begin
                    fresh = 1'b1;
                    emit  = 1'b1;
                    first = (z == r_nps);
                    if (first) begin
                        n_seg_end = zone12;
                    end
                    if (z == r_nps + SEG_W'(LEN_HI_OFS)) begin
                        n_lhb = i_byte;
                    end
                    if (z == r_nps + SEG_W'(LEN_LO_OFS)) begin
                        len  = LEN_W'({r_lhb, i_byte}) + LEN_W'(1);
                        cand = LEN_W'(r_nps) + len + LEN_W'(PKT_HDR_LEN);
                        n_seg_end = (cand < LEN_W'(zone12)) ? cand[SEG_W-1:0] : zone12;
                    end
                    last = (z + SEG_W'(1) == n_seg_end);
                    if (last) begin
                        n_nps = n_seg_end;
                    end
                end
            end

            n_pos = (pos1_c >= fl_c) ? '0 : pos1_c[POS_W-1:0];
        end
    end

    assign o_res_valid             = in_zone && emit;
    assign o_res.packet_byte       = i_byte;
    assign o_res.frame_count       = n_cur;
    assign o_res.segment_first     = first;
    assign o_res.segment_last      = last;
    assign o_res.starts_new_packet = fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_cur     <= '0;
            r_prev    <= '0;
            r_match   <= 1'b0;
            r_cont    <= 1'b0;
            r_hp      <= '0;
            r_nps     <= '0;
            r_seg_end <= '0;
            r_lhb     <= '0;
        end else begin
            r_pos     <= n_pos;
            r_cur     <= n_cur;
            r_prev    <= n_prev;
            r_match   <= n_match;
            r_cont    <= n_cont;
            r_hp      <= n_hp;
            r_nps     <= n_nps;
            r_seg_end <= n_seg_end;
            r_lhb     <= n_lhb;
        end
    end

endmodule

// File: hw/rtl/vcdu_mpdu_packet_extractor.sv
// Takes one byte of a frame-aligned transfer frame stream per clock and
// accepts a new byte in every cycle: header decode, channel filter,
// continuity check and segment marking all settle in the cycle the byte is
// taken, and the resulting data zone byte is registered in the output
// register, or in the skid register while that is held. Bytes of no
// emitted segment produce no output. The output register is backed by a
// one-entry skid register, so the input stays ready while a result waits;
// it drops only after the downstream side has stalled with both registers
// full. Writes on the plain config write port take effect on the next byte.
// depends on vmpe_pkg and vmpe_core
module vcdu_mpdu_packet_extractor #(
    parameter int MAX_FRAME_BYTES = vmpe_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [vmpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vmpe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,  // stream_byte
    // output stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [31:0]                     o_m_axis_tdata,  // packet_byte, frame_count
    output logic                            o_m_axis_tlast,  // segment_last
    output logic [1:0]                      o_m_axis_tuser   // segment_first, starts_new_packet
);
    import vmpe_pkg::*;

    t_cfg    r_cfg;
    logic    core_valid;
    logic    res_valid;
    t_result res;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    out_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_length            <= RST_FRAME_LENGTH;
            r_cfg.insert_zone_present     <= 1'b1;
            r_cfg.channel_id              <= '0;
            r_cfg.data_start              <= RST_DATA_START;
            r_cfg.data_size               <= RST_DATA_SIZE;
            r_cfg.idle_pointer_always_new <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_LENGTH: r_cfg.frame_length            <= i_cfg_data[FL_W-1:0];
                REG_INSERT_ZONE:  r_cfg.insert_zone_present     <= i_cfg_data[0];
                REG_CHANNEL_ID:   r_cfg.channel_id              <= i_cfg_data[CH_W-1:0];
                REG_DATA_START:   r_cfg.data_start              <= i_cfg_data[DS_W-1:0];
                REG_DATA_SIZE:    r_cfg.data_size               <= i_cfg_data[DS_W-1:0];
                REG_IDLE_NEW:     r_cfg.idle_pointer_always_new <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_s_axis_tready = !r_skid_valid;
    assign core_valid      = i_s_axis_tvalid && o_s_axis_tready;

    vmpe_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (core_valid),
        .i_byte      (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign out_fire = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.frame_count, r_out.packet_byte};
    assign o_m_axis_tlast  = r_out.segment_last;
    assign o_m_axis_tuser  = {r_out.starts_new_packet, r_out.segment_first};

endmodule

// File: hw/rtl/vmpe_checker.sv
// port-level checks of the packet extractor, bound to the top level
// depends on vcdu_mpdu_packet_extractor_macros.svh
`include "vcdu_mpdu_packet_extractor_macros.svh"

module vmpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic [1:0]  o_m_axis_tuser
);

    `VMPE_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser), "stalled output request changed")
    `VMPE_ASSERT_IMP(a_reset_empty, $past(!i_rst_n), !o_m_axis_tvalid, "output valid right after reset")
    `VMPE_ASSERT_IMP(a_stall_full, !o_s_axis_tready, o_m_axis_tvalid, "input stalled with empty output")
    `VMPE_ASSERT_IMP(a_stall_cause, $fell(o_s_axis_tready), $past(o_m_axis_tvalid && !i_m_axis_tready), "input stalled without output backpressure")

endmodule

bind vcdu_mpdu_packet_extractor vmpe_checker u_vmpe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// File: sim/vmpe_segment_checker.sv
// checker for the vcdu m_pdu packet extractor: mirrors config writes, predicts
// every segment byte from the accepted stream bytes and compares in order
// depends on vmpe_pkg
module vmpe_segment_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vmpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vmpe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [31:0]                     i_m_axis_tdata,
    input  logic                            i_m_axis_tlast,
    input  logic [1:0]                      i_m_axis_tuser,
    output int                              o_fail_count = 0,
    output int                              o_pending = 0,
    output int                              o_checked = 0
);
    timeunit 1ns;
    timeprecision 1ps;
    import vmpe_pkg::*;

    logic [FL_W-1:0]  cfg_fl;
    logic             cfg_iz;
    logic [CH_W-1:0]  cfg_ch;
    logic [DS_W-1:0]  cfg_ds;
    logic [DS_W-1:0]  cfg_dsz;
    logic             cfg_idle_new;

    logic [10:0]      byte_pos;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] prev_cnt;
    logic             ch_match;
    logic             cnt_cont;
    logic [PTR_W-1:0] hdr_ptr;
    logic [SEG_W-1:0] pkt_start;
    logic [SEG_W-1:0] seg_end;
    logic [7:0]       len_hi;

    t_result expected_segments[$];

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= 30)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got, input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0h want %0h at result %0d",
                                      name, got, want, o_checked));
    endtask

    function automatic void reset_extractor();
        cfg_fl       = RST_FRAME_LENGTH;
        cfg_iz       = 1'b1;
        cfg_ch       = '0;
        cfg_ds       = RST_DATA_START;
        cfg_dsz      = RST_DATA_SIZE;
        cfg_idle_new = 1'b0;
        byte_pos     = '0;
        cur_cnt      = '0;
        prev_cnt     = '0;
        ch_match     = 1'b0;
        cnt_cont     = 1'b0;
        hdr_ptr      = '0;
        pkt_start    = '0;
        seg_end      = '0;
        len_hi       = '0;
    endfunction

    function automatic void take_stream_byte(input logic [7:0] b);
        int unsigned p, fl, ptr_at, zone, z, len, cand;
        logic zone_ok, emit, first, last, fresh;
        t_result r;
        p      = byte_pos;
        fl     = cfg_fl;
        ptr_at = cfg_iz ? PTR_AT_IZ : PTR_AT_NO;
        zone   = 0;
        emit   = 1'b0;
        first  = 1'b0;
        last   = 1'b0;
        fresh  = 1'b0;
        if (fl > MAX_FRAME_BYTES_DEF) fl = MAX_FRAME_BYTES_DEF;
        if (fl == 0) fl = 1;

        if (p == 0) ch_match = 1'b0;
        if (p == POS_CHANNEL) ch_match = (b[5:0] == cfg_ch);
        if (p == POS_CNT_HI) cur_cnt = {b, 16'h0000};
        if (p == POS_CNT_MID) cur_cnt = cur_cnt | {8'h00, b, 8'h00};
        if (p == POS_CNT_LO) begin
            cur_cnt = cur_cnt | {16'h0000, b};
            if (ch_match) begin
                cnt_cont = ({1'b0, prev_cnt} + 25'd1 == {1'b0, cur_cnt});
                prev_cnt = cur_cnt;
            end
        end
        if (p == ptr_at) hdr_ptr = {b[2:0], 8'h00};
        if (p == ptr_at + 1) begin
            hdr_ptr   = hdr_ptr | {3'b000, b};
            pkt_start = {1'b0, hdr_ptr};
            seg_end   = '0;
        end

        zone_ok = (cfg_ds > ptr_at + 1) && (cfg_ds < fl);
        if (zone_ok) begin
            zone = cfg_dsz;
            if (cfg_ds + zone > fl) zone = fl - cfg_ds;
        end

        if (zone_ok && ch_match && p >= cfg_ds && p - cfg_ds < zone) begin
            z = p - cfg_ds;
            if (hdr_ptr == IDLE_POINTER) begin
                fresh = cfg_idle_new;
                emit  = fresh || cnt_cont;
                first = (z == 0);
                last  = (z + 1 == zone);
            end else if (z < hdr_ptr) begin
                fresh = 1'b0;
                emit  = cnt_cont;
                first = (z == 0);
                last  = (z + 1 == hdr_ptr) || (z + 1 == zone);
            end else begin
                fresh = 1'b1;
                emit  = 1'b1;
                first = (z == pkt_start);
                if (first) seg_end = SEG_W'(zone);
                if (z == pkt_start + LEN_HI_OFS) len_hi = b;
                if (z == pkt_start + LEN_LO_OFS) begin
                    len     = int'({len_hi, b}) + 1;
                    cand    = pkt_start + len + PKT_HDR_LEN;
                    seg_end = SEG_W'((cand < zone) ? cand : zone);
                end
                last = (z + 1 == seg_end);
                if (last) pkt_start = seg_end;
            end
            if (emit) begin
                r.packet_byte       = b;
                r.frame_count       = cur_cnt;
                r.segment_first     = first;
                r.segment_last      = last;
                r.starts_new_packet = fresh;
                expected_segments.push_back(r);
            end
        end
        byte_pos = (p + 1 >= fl) ? 11'd0 : 11'(p + 1);
    endfunction

    initial reset_extractor();

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            reset_extractor();
            expected_segments.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                take_stream_byte(i_s_axis_tdata);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_LENGTH: cfg_fl       = i_cfg_data[FL_W-1:0];
                    REG_INSERT_ZONE:  cfg_iz       = i_cfg_data[0];
                    REG_CHANNEL_ID:   cfg_ch       = i_cfg_data[CH_W-1:0];
                    REG_DATA_START:   cfg_ds       = i_cfg_data[DS_W-1:0];
                    REG_DATA_SIZE:    cfg_dsz      = i_cfg_data[DS_W-1:0];
                    REG_IDLE_NEW:     cfg_idle_new = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_segments.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, data %0h", i_m_axis_tdata));
                end else begin
                    want = expected_segments.pop_front();
                    check_field("packet_byte", i_m_axis_tdata[7:0], want.packet_byte);
                    check_field("frame_count", i_m_axis_tdata[31:8], want.frame_count);
                    check_field("segment_first", i_m_axis_tuser[0], want.segment_first);
                    check_field("segment_last", i_m_axis_tlast, want.segment_last);
                    check_field("starts_new_packet", i_m_axis_tuser[1], want.starts_new_packet);
                end
                o_checked++;
            end
        end
        o_pending = expected_segments.size();
    end

endmodule

// File: sim/tb.sv
// top of the packet extractor bench: clock, reset, register settings and
// frame-shaped byte stimulus with random gaps and stalls, plus the verdict
// depends on vmpe_pkg, vcdu_mpdu_packet_extractor and vmpe_segment_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vmpe_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [7:0]            i_s_axis_tdata = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [31:0]           o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic [1:0]            o_m_axis_tuser;

    int fail_count, pending, checked;

    vcdu_mpdu_packet_extractor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    vmpe_segment_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("run did not finish in time, pending %0d", pending);
        $display("TB_ERROR");
        $finish;
    end

    // idle rates: 0 means no idling, n means a burst starts with a chance of one in n per draw
    int tx_rate = 0;
    int rx_rate = 0;
    int rx_hold = 0;
    int bytes_sent = 0;
    int phases_run = 0;

    always @(negedge i_clk) begin
        if (rx_rate != 0 && rx_hold == 0 && $urandom_range(0, rx_rate - 1) == 0)
            rx_hold = $urandom_range(1, 18);
        if (rx_hold != 0) begin
            rx_hold--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // frame generator state, follows the block's byte position
    int               g_pos = 0;
    int               g_fl = 1;
    int               g_ptr_at = PTR_AT_IZ;
    int               g_ds = 0;
    int               g_zone = 0;
    int               g_nps = 0;
    int               g_lastzone = 0;
    logic             g_zone_ok = 1'b0;
    logic [CH_W-1:0]  g_ch = '0;
    logic             g_match = 1'b0;
    logic [CNT_W-1:0] g_cnt = '0;
    logic [CNT_W-1:0] g_prev = '0;
    logic [PTR_W-1:0] g_ptr = '0;
    logic [7:0]       g_len_hi = '0;

    function automatic logic [7:0] next_stream_byte();
        logic [7:0] b;
        int carry, z;
        b = 8'($urandom_range(0, 255));
        if (g_pos == 0) begin
            g_match = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 9))
                0:       g_cnt = 24'($urandom);
                1:       g_cnt = 24'hffffff;
                2:       g_cnt = g_prev;
                default: g_cnt = g_prev + 24'd1;
            endcase
            if (g_match) g_prev = g_cnt;
            carry = (g_nps > g_lastzone) ? g_nps - g_lastzone : 0;
            g_lastzone = g_zone;
            case ($urandom_range(0, 9))
                0: begin
                    g_ptr = IDLE_POINTER;
                    g_nps = 0;
                end
                1: begin
                    g_ptr = 11'($urandom);
                    g_nps = (g_ptr == IDLE_POINTER) ? 0 : int'(g_ptr);
                end
                2: begin
                    g_ptr = '0;
                    g_nps = 0;
                end
                default: begin
                    g_ptr = (carry >= g_zone) ? IDLE_POINTER : 11'(carry);
                    g_nps = carry;
                end
            endcase
        end
        if (g_pos == POS_CHANNEL)
            b = {b[7:6], g_match ? g_ch : g_ch ^ 6'($urandom_range(1, 63))};
        if (g_pos == POS_CNT_HI)  b = g_cnt[23:16];
        if (g_pos == POS_CNT_MID) b = g_cnt[15:8];
        if (g_pos == POS_CNT_LO)  b = g_cnt[7:0];
        if (g_pos == g_ptr_at)     b = {b[7:3], g_ptr[10:8]};
        if (g_pos == g_ptr_at + 1) b = g_ptr[7:0];
        if (g_zone_ok && g_ptr != IDLE_POINTER && g_pos >= g_ds && g_pos - g_ds < g_zone) begin
            z = g_pos - g_ds;
            // mostly short packets so that several fit into one zone
            if (z == g_nps + LEN_HI_OFS) begin
                if ($urandom_range(0, 7) != 0) b = 8'h00;
                g_len_hi = b;
            end
            if (z == g_nps + LEN_LO_OFS) begin
                if ($urandom_range(0, 7) != 0) b = 8'($urandom_range(0, 47));
                g_nps = g_nps + int'({g_len_hi, b}) + 1 + PKT_HDR_LEN;
            end
        end
        g_pos = (g_pos + 1 >= g_fl) ? 0 : g_pos + 1;
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (tx_rate != 0 && $urandom_range(0, tx_rate - 1) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        // bytes that give no result may still be in flight
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
    endtask

    task automatic apply_config(input logic [FL_W-1:0] fl, input logic iz,
                                input logic [CH_W-1:0] ch, input logic [DS_W-1:0] ds,
                                input logic [DS_W-1:0] dsz, input logic idle_new);
        wait_drained();
        write_reg(REG_FRAME_LENGTH, fl);
        write_reg(REG_INSERT_ZONE, {11'd0, iz});
        write_reg(REG_CHANNEL_ID, {6'd0, ch});
        write_reg(REG_DATA_START, {1'b0, ds});
        write_reg(REG_DATA_SIZE, {1'b0, dsz});
        write_reg(REG_IDLE_NEW, {11'd0, idle_new});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        g_fl      = (fl > MAX_FRAME_BYTES_DEF) ? MAX_FRAME_BYTES_DEF : ((fl == 0) ? 1 : int'(fl));
        g_ptr_at  = iz ? PTR_AT_IZ : PTR_AT_NO;
        g_ds      = ds;
        g_ch      = ch;
        g_zone_ok = (ds > g_ptr_at + 1) && (ds < g_fl);
        g_zone    = 0;
        if (g_zone_ok) g_zone = (ds + dsz > g_fl) ? g_fl - ds : int'(dsz);
        phases_run++;
    endtask

    function automatic int pick_rate();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 4;
            2:       return 10;
            default: return 30;
        endcase
    endfunction

    localparam int N_PHASES = 18;

    logic [7:0] directed_frame [24] = '{
        8'hff, 8'hc5, 8'h00, 8'h00, 8'h01, 8'h00, 8'hf8, 8'h02,
        8'hff, 8'h00, 8'h18, 8'h00, 8'h00, 8'h00, 8'h3c, 8'hc3,
        8'h7e, 8'ha5, 8'h5a, 8'h0f, 8'hf0, 8'hff, 8'hff, 8'h81
    };

    initial begin : stimulus
        int n, k, i, waited;
        logic [FL_W-1:0] fl;
        logic [DS_W-1:0] ds, dsz;
        logic iz;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one short frame: continuation, then a packet cut at the zone end
        apply_config(12'd24, 1'b0, 6'd5, 11'd8, 11'd16, 1'b0);
        foreach (directed_frame[j]) send_byte(directed_frame[j]);
        g_prev     = 24'd1;
        g_nps      = 0;
        g_lastzone = g_zone;

        for (k = 1; k <= N_PHASES; k++) begin
            if (k > N_PHASES - 3) begin
                tx_rate = 0;
                rx_rate = 0;
            end else begin
                tx_rate = pick_rate();
                rx_rate = pick_rate();
            end
            case (k)
                1: begin
                    apply_config(12'd8, 1'b0, 6'd0, 11'd0, 11'd0, 1'b0);
                    n = 40;
                end
                2: begin
                    apply_config(12'd0, 1'b1, 6'd63, 11'd2047, 11'd2047, 1'b1);
                    n = 12;
                end
                3: begin
                    apply_config(12'd4095, 1'b1, 6'd63, 11'd10, 11'd2047, 1'b1);
                    n = 400;
                end
                4: begin
                    apply_config(12'd40, 1'b0, 6'd21, 11'd5, 11'd30, 1'b0);
                    n = 60;
                end
                5: begin
                    apply_config(12'd48, 1'b1, 6'd42, 11'd2047, 11'd10, 1'b0);
                    n = 60;
                end
                6: begin
                    apply_config(12'd64, 1'b1, 6'd7, 11'd10, 11'd0, 1'b1);
                    n = 70;
                end
                7: begin
                    apply_config(12'd50, 1'b1, 6'd7, 11'd12, 11'd2047, 1'b0);
                    n = 110;
                end
                default: begin
                    fl = 12'($urandom_range(16, 96));
                    iz = 1'($urandom_range(0, 1));
                    ds = 11'((iz ? PTR_AT_IZ : PTR_AT_NO) + 2 + $urandom_range(0, 6));
                    if ($urandom_range(0, 3) != 0)
                        dsz = (ds < fl) ? 11'(fl - ds) : 11'd0;
                    else
                        dsz = 11'($urandom_range(0, fl));
                    apply_config(fl, iz, 6'($urandom_range(0, 63)), ds, dsz,
                                 1'($urandom_range(0, 1)));
                    n = $urandom_range(60, 120);
                end
            endcase
            for (i = 0; i < n; i++) begin
                if (k == 12 && i == n / 2) wait_drained();
                send_byte(next_stream_byte());
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (10) @(negedge i_clk);

        $display("sent %0d stream bytes over %0d register settings", bytes_sent, phases_run);
        $display("checked %0d segment bytes, %0d mismatches", checked, fail_count);
        if (pending != 0)
            $display("%0d expected segment bytes never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/vmpe_pkg.sv
hw/rtl/vmpe_core.sv
hw/rtl/vcdu_mpdu_packet_extractor.sv
hw/rtl/vmpe_checker.sv
sim/vmpe_segment_checker.sv
sim/tb.sv
